### sv/xs128_pkg.sv
package xs128_pkg;

  localparam logic [31:0] MULT_K  = 32'd1812433253;
  localparam logic [31:0] XOR_X   = 32'd123464980;
  localparam logic [31:0] XOR_Y   = 32'd3447902351;
  localparam logic [31:0] XOR_Z   = 32'd2859490775;
  localparam logic [31:0] XOR_W   = 32'd47621719;
  localparam logic [31:0] RESET_X = 32'd123456789;
  localparam logic [31:0] RESET_Y = 32'd362436069;
  localparam logic [31:0] RESET_Z = 32'd521288629;
  localparam logic [31:0] RESET_W = 32'd88675123;

  // input kind, carried on tuser
  localparam logic CMD_DRAW   = 1'b0;
  localparam logic CMD_RESEED = 1'b1;

  // round index within one scramble pass
  localparam logic [1:0] ROUND_X = 2'd0;
  localparam logic [1:0] ROUND_Y = 2'd1;
  localparam logic [1:0] ROUND_Z = 2'd2;
  localparam logic [1:0] ROUND_W = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_MIX
  } state_t;

  // seed ^= seed << 13; seed ^= seed >> 17
  function automatic logic [31:0] seed_mix(input logic [31:0] s);
    logic [31:0] a;
    a = s ^ (s << 13);
    return a ^ (a >> 17);
  endfunction

  function automatic logic [31:0] round_xor(input logic [1:0] idx);
    logic [31:0] k;
    case (idx)
      ROUND_X: k = XOR_X;
      ROUND_Y: k = XOR_Y;
      ROUND_Z: k = XOR_Z;
      default: k = XOR_W;
    endcase
    return k;
  endfunction

endpackage

### sv/xorshift128_generator.sv
// xorshift128 generator. Each item on the slave side is a draw (tuser = 0)
// or a reseed (tuser = 1, seed in tdata). A draw advances the four state
// words by one xorshift128 step and returns the new w word (tdata[31:0])
// and x word (tdata[63:32]), together a 64-bit fraction w:x with an implied
// half LSB. A draw is taken straight from the idle state, so draws run back to
// back while the master side keeps up. A reseed returns nothing; after it is
// taken the slave side stays busy for one pass, or two when the first pass
// leaves all four words zero: the four scramble rounds share one 32x32
// multiplier, each round a multiply state (ST_MUL) and then a state that
// mixes and stores a word (ST_MIX). The slave side is ready only while no
// reseed runs and the result register is empty or being taken.
module xorshift128_generator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] seed_value
  input  logic        s_axis_tuser,   // [0] command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // [31:0] upper_word, [63:32] lower_word
);

  xs128_pkg::state_t state, state_next;

  logic [31:0] word_x, word_y, word_z, word_w;
  logic [31:0] seed;       // running scramble seed
  logic [31:0] prod;       // registered seed * K + 1
  logic [1:0]  round;      // word being produced in this pass
  logic        pass;       // second pass after an all-zero result
  logic        out_valid;
  logic [31:0] out_upper, out_lower;

  logic        in_take;
  logic        do_draw;
  logic        do_reseed;
  logic        pass_zero;
  logic [31:0] mix_seed;
  logic [31:0] mix_word;
  logic [31:0] draw_t;
  logic [31:0] draw_w;

  // handshake decode
  always_comb begin
    s_axis_tready = (state == xs128_pkg::ST_IDLE) && (!out_valid || m_axis_tready);
    in_take       = s_axis_tvalid && s_axis_tready;
    do_draw       = in_take && (s_axis_tuser == xs128_pkg::CMD_DRAW);
    do_reseed     = in_take && (s_axis_tuser == xs128_pkg::CMD_RESEED);
  end

  // datapath terms
  always_comb begin
    mix_seed  = xs128_pkg::seed_mix(prod);
    mix_word  = xs128_pkg::round_xor(round) ^ mix_seed;
    // last round: x, y, z already stored this pass, w is being stored now
    pass_zero = ((word_x | word_y | word_z | mix_word) == 32'd0);
    draw_t    = word_x ^ (word_x << 11);
    draw_w    = word_w ^ draw_t ^ (draw_t >> 8) ^ (word_w >> 19);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      xs128_pkg::ST_IDLE: begin
        if (do_reseed) state_next = xs128_pkg::ST_MUL;
      end
      xs128_pkg::ST_MUL: begin
        state_next = xs128_pkg::ST_MIX;
      end
      xs128_pkg::ST_MIX: begin
        if (round != xs128_pkg::ROUND_W) state_next = xs128_pkg::ST_MUL;
        else if (pass_zero && !pass) state_next = xs128_pkg::ST_MUL;
        else state_next = xs128_pkg::ST_IDLE;
      end
      default: state_next = xs128_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= xs128_pkg::ST_IDLE;
      out_valid <= 1'b0;
      round     <= xs128_pkg::ROUND_X;
      pass      <= 1'b0;
      word_x    <= xs128_pkg::RESET_X;
      word_y    <= xs128_pkg::RESET_Y;
      word_z    <= xs128_pkg::RESET_Z;
      word_w    <= xs128_pkg::RESET_W;
    end else begin
      state <= state_next;

      if (do_draw) out_valid <= 1'b1;
      else if (m_axis_tready) out_valid <= 1'b0;

      case (state)
        xs128_pkg::ST_IDLE: begin
          if (do_reseed) begin
            seed  <= s_axis_tdata;
            round <= xs128_pkg::ROUND_X;
            pass  <= 1'b0;
          end
          if (do_draw) begin
            word_x    <= word_y;
            word_y    <= word_z;
            word_z    <= word_w;
            word_w    <= draw_w;
            out_upper <= draw_w;
            out_lower <= word_y;
          end
        end
        xs128_pkg::ST_MUL: begin
          prod <= seed * xs128_pkg::MULT_K + 32'd1;
        end
        xs128_pkg::ST_MIX: begin
          seed <= mix_seed;
          case (round)
            xs128_pkg::ROUND_X: word_x <= mix_word;
            xs128_pkg::ROUND_Y: word_y <= mix_word;
            xs128_pkg::ROUND_Z: word_z <= mix_word;
            default:            word_w <= mix_word;
          endcase
          round <= round + 2'd1;   // wraps to ROUND_X after w
          if (round == xs128_pkg::ROUND_W) pass <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_lower, out_upper};

endmodule

### tb/xs128_checker.sv
`timescale 1ns / 100ps

// Watches both stream channels, keeps its own copy of the generator state
// and compares every draw result against the predicted w:x pair.
module xs128_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] seed_value
  input  logic        s_axis_tuser,   // [0] command
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,   // [31:0] upper_word, [63:32] lower_word
  output int          fail_count,
  output int          pending_count
);

  typedef struct packed {
    logic [31:0] upper;
    logic [31:0] lower;
  } draw_t;

  draw_t       expected_draws[$];
  logic [31:0] st_x, st_y, st_z, st_w;

  function automatic logic [31:0] seed_round(input logic [31:0] s);
    logic [31:0] v;
    v = s * xs128_pkg::MULT_K + 32'd1;
    v = v ^ (v << 13);
    return v ^ (v >> 17);
  endfunction

  // four rounds per pass; one extra pass only if the first left all zero
  function automatic void reseed_state(input logic [31:0] seed);
    logic [31:0] s;
    s = seed;
    for (int pass = 0; pass < 2; pass++) begin
      s = seed_round(s);
      st_x = xs128_pkg::XOR_X ^ s;
      s = seed_round(s);
      st_y = xs128_pkg::XOR_Y ^ s;
      s = seed_round(s);
      st_z = xs128_pkg::XOR_Z ^ s;
      s = seed_round(s);
      st_w = xs128_pkg::XOR_W ^ s;
      if ((st_x | st_y | st_z | st_w) != 32'd0) break;
    end
  endfunction

  function automatic draw_t next_draw();
    logic [31:0] t;
    draw_t       d;
    t    = st_x ^ (st_x << 11);
    st_x = st_y;
    st_y = st_z;
    st_z = st_w;
    st_w = st_w ^ t ^ (t >> 8) ^ (st_w >> 19);
    d.upper = st_w;
    d.lower = st_x;
    return d;
  endfunction

  always @(posedge clk) begin
    draw_t got, want;
    int    errs;
    errs = 0;
    if (rst) begin
      st_x = xs128_pkg::RESET_X;
      st_y = xs128_pkg::RESET_Y;
      st_z = xs128_pkg::RESET_Z;
      st_w = xs128_pkg::RESET_W;
      expected_draws.delete();
      fail_count    <= 0;
      pending_count <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == xs128_pkg::CMD_RESEED) begin
          reseed_state(s_axis_tdata);
        end else begin
          expected_draws.push_back(next_draw());
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.upper = m_axis_tdata[31:0];
        got.lower = m_axis_tdata[63:32];
        if (expected_draws.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h:%h",
                   $time, got.upper, got.lower);
          errs++;
        end else begin
          want = expected_draws.pop_front();
          if (got.upper !== want.upper) begin
            $display("%0t: upper_word mismatch, expected %h, actual %h",
                     $time, want.upper, got.upper);
            errs++;
          end
          if (got.lower !== want.lower) begin
            $display("%0t: lower_word mismatch, expected %h, actual %h",
                     $time, want.lower, got.lower);
            errs++;
          end
        end
      end
      fail_count    <= fail_count + errs;
      pending_count <= expected_draws.size();
    end
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  // receiver stall patterns, picked at random as the run goes on
  typedef enum logic [1:0] {
    RX_OPEN,    // always ready
    RX_COIN,    // ready half the time
    RX_SLOW,    // ready only when rx_cycle mod 4 is 3
    RX_LIGHT    // occasional random stall
  } rx_mode_t;

  // all block inputs start known
  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = 32'd0;   // [31:0] seed_value
  logic        s_axis_tuser  = xs128_pkg::CMD_DRAW; // [0] command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;            // [31:0] upper_word, [63:32] lower_word

  int       fail_count;
  int       pending_count;
  int       burst_left = 0;
  rx_mode_t rx_mode    = RX_OPEN;
  int       rx_cycle   = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  xorshift128_generator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  xs128_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // Receiver: the stall pattern is picked anew at random, so stalls land on
  // draws, on reseeds in flight, and there are long fully-open stretches.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_cycle      <= 0;
      rx_mode       <= RX_OPEN;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 128 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_OPEN:  m_axis_tready <= 1'b1;
        RX_COIN:  m_axis_tready <= 1'($urandom_range(0, 1));
        RX_SLOW:  m_axis_tready <= (rx_cycle % 4 == 3);
        default:  m_axis_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Sender: items come in bursts of random length with random gaps.
  // tvalid stays high between items inside a burst, so it is never
  // lowered and raised within one step.
  task automatic send_item(input logic cmd, input logic [31:0] seed);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= seed;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  initial begin
    logic [31:0] seed;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: draws straight from the reset state
    repeat (4) send_item(xs128_pkg::CMD_DRAW, 32'd0);
    // seed extremes and alternating patterns, each followed by draws
    send_item(xs128_pkg::CMD_RESEED, 32'h0000_0000);
    repeat (2) send_item(xs128_pkg::CMD_DRAW, 32'd0);
    send_item(xs128_pkg::CMD_RESEED, 32'hFFFF_FFFF);
    // seed bits ignored on a draw
    repeat (2) send_item(xs128_pkg::CMD_DRAW, 32'hFFFF_FFFF);
    send_item(xs128_pkg::CMD_RESEED, 32'hAAAA_AAAA);
    send_item(xs128_pkg::CMD_DRAW, 32'h5555_5555);
    send_item(xs128_pkg::CMD_RESEED, 32'h5555_5555);
    send_item(xs128_pkg::CMD_DRAW, 32'hAAAA_AAAA);
    // back-to-back reseeds: only the last one should stick
    send_item(xs128_pkg::CMD_RESEED, 32'h0000_0001);
    send_item(xs128_pkg::CMD_RESEED, 32'h8000_0000);
    repeat (3) send_item(xs128_pkg::CMD_DRAW, 32'd0);
    // the published xor constant as a seed
    send_item(xs128_pkg::CMD_RESEED, xs128_pkg::XOR_W);
    send_item(xs128_pkg::CMD_DRAW, 32'd0);

    // random: mostly draws, reseeds now and then with varied seed shapes
    for (int n = 0; n < 1950; n++) begin
      if ($urandom_range(0, 11) == 0) begin
        case ($urandom_range(0, 3))
          0:       seed = 32'h1 << $urandom_range(0, 31);
          1:       seed = ~(32'h1 << $urandom_range(0, 31));
          default: seed = $urandom;
        endcase
        send_item(xs128_pkg::CMD_RESEED, seed);
      end else begin
        send_item(xs128_pkg::CMD_DRAW, $urandom);
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain: all draws back, then room for a trailing reseed and any stray result
    while (pending_count != 0) @(posedge clk);
    repeat (24) @(posedge clk);

    if (fail_count == 0 && pending_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
